// ===== sv/cfseq_pkg.sv =====
package cfseq_pkg;

    // Frame words
    localparam logic [31:0] UNLOCK_WORD = 32'hAAAA_AAAA;
    localparam logic [31:0] LOCK_WORD   = 32'hBBBB_BBBB;

    // CRC5: poly x^5 + x^2 + 1, init 0, no inversion, over bits 31..5 of a word
    localparam logic [4:0] CRC5_POLY = 5'h05;
    localparam logic [4:0] CRC5_MASK = 5'h1F;
    localparam int         CRC_BITS  = 27;

    // Command word field codes
    localparam logic [1:0] MODE_CFG      = 2'd1;
    localparam logic [2:0] SUB_READ      = 3'd0;
    localparam logic [2:0] SUB_FREQ      = 3'd1;
    localparam logic [2:0] SUB_BASE_HI   = 3'd2;
    localparam logic [2:0] SUB_BASE_LO   = 3'd3;
    localparam logic [2:0] SUB_RANGE     = 3'd4;
    localparam logic [2:0] SUB_READ_RNG  = 3'd3;   // read-range keeps submode 3
    localparam logic [7:0] RD_SEL_FREQ   = 8'd1;
    localparam logic [7:0] RD_SEL_BASE   = 8'd2;
    localparam logic [7:0] RD_SEL_RANGE  = 8'd3;

    // Command queue and byte sequencing
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int CNT_W    = 5;
    localparam int MAX_CMDS = 4;
    localparam int NCMD_W   = 3;

    typedef enum logic [2:0] {
        ACT_SET_FREQ   = 3'd0,
        ACT_SET_BASE   = 3'd1,
        ACT_SET_RANGE  = 3'd2,
        ACT_READ_FREQ  = 3'd3,
        ACT_READ_BASE  = 3'd4,
        ACT_READ_RANGE = 3'd5
    } action_t;

    // One decoded command, as handed from front to back
    typedef struct packed {
        logic [MAX_CMDS-1:0][31:0] words;
        logic [NCMD_W-1:0]         n_cmd;
        logic [CNT_W-1:0]          last_ix;
    } cmd_entry_t;

    typedef struct packed {
        logic full;
        logic avail;
    } q_stat_t;

    // Bit-serial CRC5 reference, only evaluated at elaboration for the basis
    function automatic logic [4:0] crc5_serial(input logic [CRC_BITS-1:0] d);
        logic [4:0] c;
        logic       fb;
        c = '0;
        for (int k = CRC_BITS - 1; k >= 0; k--) begin
            fb = c[4] ^ d[k];
            c  = (c << 1) & CRC5_MASK;
            if (fb)
                c = c ^ CRC5_POLY;
        end
        return c;
    endfunction

    function automatic logic [CRC_BITS*5-1:0] crc5_basis_f();
        logic [CRC_BITS*5-1:0] b;
        b = '0;
        for (int k = 0; k < CRC_BITS; k++)
            b[k*5 +: 5] = crc5_serial(CRC_BITS'(1) << k);
        return b;
    endfunction

    // CRC of each single set input bit; CRC is linear so the rest is XOR
    localparam logic [CRC_BITS*5-1:0] CRC5_BASIS = crc5_basis_f();

    function automatic logic [4:0] crc5_fast(input logic [CRC_BITS-1:0] d);
        logic [4:0] c;
        c = '0;
        for (int k = 0; k < CRC_BITS; k++)
            if (d[k])
                c = c ^ CRC5_BASIS[k*5 +: 5];
        return c;
    endfunction

    function automatic logic [31:0] make_word(
        input logic       wr,
        input logic       bc,
        input logic [1:0] mode,
        input logic [2:0] sub,
        input logic       half,
        input logic [7:0] b1,
        input logic [7:0] b2
    );
        logic [31:0] w;
        w = {wr, bc, mode, sub, half, b1, b2, 8'h00};
        w[4:0] = crc5_fast(w[31:5]);
        return w;
    endfunction

endpackage

// ===== sv/cfseq_front.sv =====
module cfseq_front (
    input  logic                  push,
    input  logic                  full,
    input  logic [2:0]            action,
    input  logic [7:0]            asic_id,
    input  logic [31:0]           value,
    output logic                  q_wr,
    output cfseq_pkg::cmd_entry_t q_data
);
    import cfseq_pkg::*;

    logic known;

    // Decode the command into its command words
    always_comb
    begin
        known  = 1'b1;
        q_data = '0;
        case (action_t'(action))
            ACT_SET_FREQ:
            begin
                q_data.words[0] = make_word(1'b1, 1'b1, MODE_CFG, SUB_FREQ, 1'b0,
                                            value[15:8], value[7:0]);
                q_data.n_cmd   = NCMD_W'(1);
                q_data.last_ix = CNT_W'(19);
            end
            ACT_SET_BASE:
            begin
                q_data.words[0] = make_word(1'b1, 1'b0, MODE_CFG, SUB_BASE_HI, 1'b1,
                                            asic_id, value[31:24]);
                q_data.words[1] = make_word(1'b1, 1'b0, MODE_CFG, SUB_BASE_HI, 1'b0,
                                            asic_id, value[23:16]);
                q_data.words[2] = make_word(1'b1, 1'b0, MODE_CFG, SUB_BASE_LO, 1'b1,
                                            asic_id, value[15:8]);
                q_data.words[3] = make_word(1'b1, 1'b0, MODE_CFG, SUB_BASE_LO, 1'b0,
                                            asic_id, value[7:0]);
                q_data.n_cmd   = NCMD_W'(4);
                q_data.last_ix = CNT_W'(31);
            end
            ACT_SET_RANGE:
            begin
                q_data.words[0] = make_word(1'b1, 1'b1, MODE_CFG, SUB_RANGE, 1'b1,
                                            value[31:24], value[23:16]);
                q_data.words[1] = make_word(1'b1, 1'b1, MODE_CFG, SUB_RANGE, 1'b0,
                                            value[15:8], value[7:0]);
                q_data.n_cmd   = NCMD_W'(2);
                q_data.last_ix = CNT_W'(23);
            end
            ACT_READ_FREQ:
            begin
                q_data.words[0] = make_word(1'b0, 1'b0, MODE_CFG, SUB_READ, 1'b0,
                                            asic_id, RD_SEL_FREQ);
                q_data.n_cmd   = NCMD_W'(1);
                q_data.last_ix = CNT_W'(19);
            end
            ACT_READ_BASE:
            begin
                q_data.words[0] = make_word(1'b0, 1'b0, MODE_CFG, SUB_READ, 1'b0,
                                            asic_id, RD_SEL_BASE);
                q_data.n_cmd   = NCMD_W'(1);
                q_data.last_ix = CNT_W'(19);
            end
            ACT_READ_RANGE:
            begin
                q_data.words[0] = make_word(1'b0, 1'b0, MODE_CFG, SUB_READ_RNG, 1'b0,
                                            asic_id, RD_SEL_RANGE);
                q_data.n_cmd   = NCMD_W'(1);
                q_data.last_ix = CNT_W'(19);
            end
            default:
            begin
                known = 1'b0;   // undefined actions are accepted and dropped
            end
        endcase
    end

    assign q_wr = push && !full && known;

endmodule

// ===== sv/cfseq_queue.sv =====
module cfseq_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr,
    input  cfseq_pkg::cmd_entry_t wr_data,
    input  logic                  rd,
    output cfseq_pkg::cmd_entry_t rd_data,
    output cfseq_pkg::q_stat_t    stat
);
    import cfseq_pkg::*;

    cmd_entry_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;
    logic               do_wr, do_rd;

    assign stat.full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign stat.avail = (count_reg != '0);
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && stat.avail;
    assign rd_data    = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== sv/cfseq_back.sv =====
module cfseq_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfseq_pkg::cmd_entry_t head,
    input  logic                  head_valid,
    output logic                  q_rd,
    input  logic                  pop,
    output logic                  empty,
    output logic [7:0]            tx_byte,
    output logic                  last_byte
);
    import cfseq_pkg::*;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        tx_byte_reg;
    logic              last_reg;
    logic              load;
    logic              is_last;
    logic [2:0]        word_ix;
    logic [2:0]        cmd_ix;
    logic [31:0]       cur_word;
    logic [7:0]        cur_byte;

    // Output register takes a new beat when empty or being drained
    assign load    = head_valid && (!out_valid_reg || pop);
    assign is_last = (cnt_reg == head.last_ix);
    assign q_rd    = load && is_last;

    // Word and byte selection for the current beat
    always_comb
    begin
        word_ix = cnt_reg[CNT_W-1:2];
        cmd_ix  = word_ix - 3'd2;
        if (word_ix < 3'd2)
            cur_word = UNLOCK_WORD;
        else if (cmd_ix < head.n_cmd)
            cur_word = head.words[cmd_ix[1:0]];
        else
            cur_word = LOCK_WORD;
        case (cnt_reg[1:0])
            2'd0:    cur_byte = cur_word[31:24];
            2'd1:    cur_byte = cur_word[23:16];
            2'd2:    cur_byte = cur_word[15:8];
            default: cur_byte = cur_word[7:0];
        endcase
    end

    // Beat counter and output valid
    always_comb
    begin
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            cnt_next       = is_last ? '0 : cnt_reg + 1'b1;
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tx_byte_reg <= cur_byte;
            last_reg    <= is_last;
        end
    end

    assign empty     = !out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign last_byte = last_reg;

endmodule

// ===== sv/crc5_command_frame_sequencer.sv =====
// A command's first byte reaches the result ports via the command queue and then the single
// byte-serial output register, once free; bytes leave one per cycle while pop is held high.
// A frame is 20 bytes (set frequency, reads), 24 (set range) or 32 (set base nonce).
// A two-entry command queue lets the next command be pushed while the current one streams out.
// Reset (rst_n low, asynchronous) empties the queue and the output register; no clearing pass.
module crc5_command_frame_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  action,
    input  logic [7:0]  asic_id,
    input  logic [31:0] value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  tx_byte,
    output logic        last_byte
);
    import cfseq_pkg::*;

    cmd_entry_t q_wr_data;
    cmd_entry_t q_head;
    q_stat_t    q_stat;
    logic       q_wr;
    logic       q_rd;

    assign full = q_stat.full;

    // Front: decode and CRC
    cfseq_front u_front (
        .push    (push),
        .full    (q_stat.full),
        .action  (action),
        .asic_id (asic_id),
        .value   (value),
        .q_wr    (q_wr),
        .q_data  (q_wr_data)
    );

    // Command queue
    cfseq_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .rd      (q_rd),
        .rd_data (q_head),
        .stat    (q_stat)
    );

    // Back: byte sequencer
    cfseq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (q_stat.avail),
        .q_rd       (q_rd),
        .pop        (pop),
        .empty      (empty),
        .tx_byte    (tx_byte),
        .last_byte  (last_byte)
    );

    // A frame always closes on a lock byte
    a_last_is_lock: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_byte) |-> (tx_byte == LOCK_WORD[7:0]))
        else $error("last beat is not a lock byte");

    // Within a frame the next beat follows without a bubble
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_byte) |=> !empty)
        else $error("bubble inside a frame");

    // A full queue implies the back end is already streaming
    a_full_streaming: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("queue full while output is empty");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import cfseq_pkg::*;

    // Reserved action codes: the block emits nothing for these
    localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

    // Two long receiver hold-offs, in clock cycles after reset
    localparam int HOLD1_START = 300;
    localparam int HOLD1_END   = 500;
    localparam int HOLD2_START = 3000;
    localparam int HOLD2_END   = 3250;

    localparam int RANDOM_CMDS = 263;
    localparam int TIMEOUT     = 10000000;

    typedef struct {
        logic [2:0]  act;
        logic [7:0]  id;
        logic [31:0] val;
    } cmd_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } tx_beat_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    logic [2:0]  action    = '0;
    logic [7:0]  asic_id   = '0;
    logic [31:0] value     = '0;
    logic        empty;
    logic        pop       = 1'b0;
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic        hold      = 1'b0;

    cmd_item_t pending_cmds[$];
    tx_beat_t  frame_beats[$];

    int burst_left = 0;
    int gap_left   = 0;
    int full_stalls = 0;
    int beats_checked = 0;
    int errors = 0;
    int act_hits[8];
    int hold_cyc = 0;
    int rx_phase = 0;
    logic [7:0] rx_pat = 8'hFF;

    crc5_command_frame_sequencer DUT (.*);

    // Clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // CRC5 over bits 31..5, shifted in MSB first
    function automatic logic [4:0] crc5_over(input logic [31:0] w);
        logic [4:0] r;
        logic       fb;
        r = '0;
        for (int i = 31; i >= 5; i--)
        begin
            fb = r[4] ^ w[i];
            r  = {r[3:0], 1'b0};
            if (fb)
                r = r ^ CRC5_POLY;
        end
        return r;
    endfunction

    function automatic logic [31:0] cmd_word(input logic wr, input logic bc,
                                             input logic [2:0] sub, input logic half,
                                             input logic [7:0] b1, input logic [7:0] b2);
        logic [31:0] w;
        w = {wr, bc, MODE_CFG, sub, half, b1, b2, 8'h00};
        w[4:0] = crc5_over(w);
        return w;
    endfunction

    // Expected byte stream of one command, appended to frame_beats
    function automatic void queue_frame(input cmd_item_t c);
        logic [31:0] words[$];
        tx_beat_t    b;
        if (c.act == ACT_UNUSED_LO || c.act == ACT_UNUSED_HI)
            return;
        words.push_back(UNLOCK_WORD);
        words.push_back(UNLOCK_WORD);
        case (c.act)
            ACT_SET_FREQ:
                words.push_back(cmd_word(1'b1, 1'b1, SUB_FREQ, 1'b0, c.val[15:8], c.val[7:0]));
            ACT_SET_BASE:
            begin
                words.push_back(cmd_word(1'b1, 1'b0, SUB_BASE_HI, 1'b1, c.id, c.val[31:24]));
                words.push_back(cmd_word(1'b1, 1'b0, SUB_BASE_HI, 1'b0, c.id, c.val[23:16]));
                words.push_back(cmd_word(1'b1, 1'b0, SUB_BASE_LO, 1'b1, c.id, c.val[15:8]));
                words.push_back(cmd_word(1'b1, 1'b0, SUB_BASE_LO, 1'b0, c.id, c.val[7:0]));
            end
            ACT_SET_RANGE:
            begin
                words.push_back(cmd_word(1'b1, 1'b1, SUB_RANGE, 1'b1,
                                         c.val[31:24], c.val[23:16]));
                words.push_back(cmd_word(1'b1, 1'b1, SUB_RANGE, 1'b0, c.val[15:8], c.val[7:0]));
            end
            ACT_READ_FREQ:
                words.push_back(cmd_word(1'b0, 1'b0, SUB_READ, 1'b0, c.id, RD_SEL_FREQ));
            ACT_READ_BASE:
                words.push_back(cmd_word(1'b0, 1'b0, SUB_READ, 1'b0, c.id, RD_SEL_BASE));
            default:
                // read range keeps submode 3
                words.push_back(cmd_word(1'b0, 1'b0, SUB_READ_RNG, 1'b0, c.id, RD_SEL_RANGE));
        endcase
        words.push_back(LOCK_WORD);
        words.push_back(LOCK_WORD);
        foreach (words[i])
        begin
            for (int k = 0; k < 4; k++)
            begin
                b.data = words[i][31 - 8 * k -: 8];
                b.last = (i == words.size() - 1) && (k == 3);
                frame_beats.push_back(b);
            end
        end
    endfunction

    task automatic add_cmd(input logic [2:0] act, input logic [7:0] id, input logic [31:0] val);
        cmd_item_t c;
        c.act = act;
        c.id  = id;
        c.val = val;
        pending_cmds.push_back(c);
    endtask

    task automatic build_stimulus();
        logic [2:0]  act;
        logic [31:0] val;
        int          legal;
        legal = 0;
        // directed: field extremes, every action, reserved codes
        add_cmd(ACT_SET_FREQ,   8'h00, 32'h0000_0000);
        add_cmd(ACT_SET_FREQ,   8'hFF, 32'hFFFF_FFFF);
        add_cmd(ACT_SET_FREQ,   8'h3C, 32'h1234_A55A);
        add_cmd(ACT_SET_BASE,   8'h00, 32'h0000_0000);
        add_cmd(ACT_SET_BASE,   8'hFF, 32'hFFFF_FFFF);
        add_cmd(ACT_SET_BASE,   8'h80, 32'h1234_5678);
        add_cmd(ACT_SET_BASE,   8'h01, 32'h8000_0001);
        add_cmd(ACT_SET_RANGE,  8'h00, 32'h0000_0000);
        add_cmd(ACT_SET_RANGE,  8'hFF, 32'hFFFF_FFFF);
        add_cmd(ACT_SET_RANGE,  8'h7F, 32'h55AA_33CC);
        add_cmd(ACT_READ_FREQ,  8'h00, 32'hFFFF_FFFF);
        add_cmd(ACT_READ_FREQ,  8'hFF, 32'h0000_0000);
        add_cmd(ACT_READ_BASE,  8'h00, 32'hDEAD_BEEF);
        add_cmd(ACT_READ_BASE,  8'hFF, 32'h0000_0000);
        add_cmd(ACT_READ_RANGE, 8'h00, 32'h0000_0000);
        add_cmd(ACT_READ_RANGE, 8'hFF, 32'hFFFF_FFFF);
        add_cmd(ACT_READ_RANGE, 8'h5A, 32'hAAAA_5555);
        add_cmd(ACT_UNUSED_LO,  8'hFF, 32'hFFFF_FFFF);
        add_cmd(ACT_UNUSED_HI,  8'h00, 32'h0000_0000);
        // random: mostly valid commands, a few reserved codes mixed in
        while (legal < RANDOM_CMDS)
        begin
            if ($urandom_range(0, 19) == 0)
                act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
            else
                act = 3'($urandom_range(ACT_SET_FREQ, ACT_READ_RANGE));
            case ($urandom_range(0, 7))
                0:       val = '0;
                1:       val = '1;
                default: val = $urandom;
            endcase
            add_cmd(act, 8'($urandom_range(0, 255)), val);
            if (act <= ACT_READ_RANGE)
                legal++;
        end
    endtask

    // Driver: offers commands in bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && full)
                full_stalls++;
            if (push && !full)
            begin
                queue_frame(pending_cmds[0]);
                act_hits[pending_cmds[0].act]++;
                pending_cmds.delete(0);
            end
            if (!push || !full)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    push <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    push    <= 1'b1;
                    action  <= pending_cmds[0].act;
                    asic_id <= pending_cmds[0].id;
                    value   <= pending_cmds[0].val;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 10);
                        // long gaps land on every phase of a 20..32 byte frame
                        if ($urandom_range(0, 3) == 0)
                            gap_left = $urandom_range(0, 40);
                        else
                            gap_left = $urandom_range(0, 2);
                    end
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-offs so the command queue fills and full rises
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cyc = 0;
            hold <= 1'b0;
        end
        else
        begin
            hold_cyc++;
            hold <= (hold_cyc >= HOLD1_START && hold_cyc < HOLD1_END) ||
                    (hold_cyc >= HOLD2_START && hold_cyc < HOLD2_END);
        end
    end

    // Monitor: checks each popped beat, then drives pop from a rotating pattern
    always @(posedge clk or negedge rst_n)
    begin
        tx_beat_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (frame_beats.size() == 0)
                begin
                    $error("unexpected beat: tx_byte=%02h last_byte=%0b", tx_byte, last_byte);
                    errors++;
                end
                else
                begin
                    want = frame_beats.pop_front();
                    if (tx_byte !== want.data)
                    begin
                        $error("tx_byte mismatch: expected %02h, actual %02h",
                               want.data, tx_byte);
                        errors++;
                    end
                    if (last_byte !== want.last)
                    begin
                        $error("last_byte mismatch: expected %0b, actual %0b",
                               want.last, last_byte);
                        errors++;
                    end
                    beats_checked++;
                end
            end
            // new stall pattern each time rx_phase wraps; a third of them never stall
            if (rx_phase == 0)
            begin
                if ($urandom_range(0, 2) == 0)
                    rx_pat = 8'hFF;
                else
                    rx_pat = 8'($urandom_range(1, 255));
            end
            rx_phase = (rx_phase + 1) % 64;
            rx_pat   = {rx_pat[0], rx_pat[7:1]};
            pop <= rx_pat[0] && !hold;
        end
    end

    // Reset, run to completion, report
    initial
    begin
        build_stimulus();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_cmds.size() != 0 || push)
            @(posedge clk);
        while (frame_beats.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Commands sent: freq %0d, base %0d, range %0d, reads %0d/%0d/%0d, reserved %0d",
                 act_hits[ACT_SET_FREQ], act_hits[ACT_SET_BASE], act_hits[ACT_SET_RANGE],
                 act_hits[ACT_READ_FREQ], act_hits[ACT_READ_BASE], act_hits[ACT_READ_RANGE],
                 act_hits[ACT_UNUSED_LO] + act_hits[ACT_UNUSED_HI]);
        $display("Frame bytes checked: %0d, cycles input stalled on full: %0d, errors: %0d",
                 beats_checked, full_stalls, errors);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #TIMEOUT;
        $error("timeout: %0d commands pending, %0d bytes still expected",
               pending_cmds.size(), frame_beats.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
